[hdl/rde_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_pkg: shared types and constants of the radix digit emitter
// Widths, register indexes, reset values, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rde_pkg;

  // Value and digit geometry
  localparam int unsigned VALUE_W       = 64;
  localparam int unsigned DIGIT_W       = 5;
  localparam int unsigned CHAR_W        = 8;
  localparam int unsigned RADIX_W       = 6;
  localparam int unsigned MAX_DIGITS    = 64;
  localparam int unsigned TABLE_ENTRIES = 32;
  localparam int unsigned ADDR_W        = $clog2(MAX_DIGITS);
  localparam int unsigned CNT_W         = $clog2(MAX_DIGITS + 1);

  // Divider: quotient bits retired per clock
  localparam int unsigned BITS_PER_CYC  = 8;
  localparam int unsigned DIV_CYCLES    = VALUE_W / BITS_PER_CYC;
  localparam int unsigned STEP_W        = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // Radix clamp limits
  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(32);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CHAR_WORDS = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX   = 3'd0,
    REG_CHARS_0 = 3'd1,
    REG_CHARS_1 = 3'd2,
    REG_CHARS_2 = 3'd3,
    REG_CHARS_3 = 3'd4
  } cfg_reg_e;

  localparam logic [RADIX_W-1:0]    RADIX_RESET   = RADIX_W'(10);
  localparam logic [CFG_DATA_W-1:0] CHARS0_RESET  = 64'h3736353433323130;
  localparam logic [CFG_DATA_W-1:0] CHARS1_RESET  = 64'h6665646362613938;
  localparam logic [CFG_DATA_W-1:0] CHARS2_RESET  = 64'h0;
  localparam logic [CFG_DATA_W-1:0] CHARS3_RESET  = 64'h0;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = VALUE_W;
  localparam int unsigned OUT_TDATA_W = 16;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_EMIT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture a new value, clear count
    logic div_step;  // run one divider clock
    logic rd_issue;  // read the digit buffer at the read pointer
    logic out_load;  // move the read digit into the output register
  } rde_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic step_last;  // this divider clock finishes a digit
    logic conv_done;  // the finished digit is the most significant one
    logic out_free;   // output register can take a digit this cycle
    logic rd_last;    // read pointer sits on the least significant digit
  } rde_status_t;

endpackage

[hdl/rde_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_ctrl: conversion sequencer
// Walks each value through division, then reads the buffered digits back
// most significant first and hands them to the output register.
// ----------------------------------------------------------------------------
module rde_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  rde_pkg::rde_status_t status_i,
  output rde_pkg::rde_cmd_t    cmd_o
);

  rde_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rde_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rde_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_d = rde_pkg::ST_DIV;
      end
      rde_pkg::ST_DIV: begin
        if (status_i.step_last && status_i.conv_done) state_d = rde_pkg::ST_READ;
      end
      rde_pkg::ST_READ: begin
        state_d = rde_pkg::ST_EMIT;
      end
      rde_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = status_i.rd_last ? rde_pkg::ST_IDLE : rde_pkg::ST_READ;
        end
      end
      default: state_d = rde_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      rde_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.load    = s_axis_tvalid;
      end
      rde_pkg::ST_DIV:  cmd_o.div_step = 1'b1;
      rde_pkg::ST_READ: cmd_o.rd_issue = 1'b1;
      rde_pkg::ST_EMIT: cmd_o.out_load = status_i.out_free;
      default: ;
    endcase
  end

endmodule

[hdl/rde_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_datapath: divider, digit buffer, digit table and output register
// Divides the value by the radix at BITS_PER_CYC quotient bits per clock, stores each
// remainder, and maps read-back digits to characters.
// ----------------------------------------------------------------------------
module rde_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_we_i,
  input  logic [rde_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [rde_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  // input payload: [63:0] value
  input  logic [rde_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
  // output stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [7:0] digit_char, [12:8] digit_value, [15:13] zero
  output logic [rde_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  output logic                                  m_axis_tlast,
  // controller link
  input  rde_pkg::rde_cmd_t                     cmd_i,
  output rde_pkg::rde_status_t                  status_o
);

  localparam int unsigned VW = rde_pkg::VALUE_W;
  localparam int unsigned DW = rde_pkg::DIGIT_W;
  localparam int unsigned RW = rde_pkg::RADIX_W;
  localparam int unsigned AW = rde_pkg::ADDR_W;
  localparam int unsigned CW = rde_pkg::CNT_W;
  localparam int unsigned SW = rde_pkg::STEP_W;

  // Configuration registers
  logic [RW-1:0]                                   radix_q;
  logic [rde_pkg::CHAR_WORDS-1:0][rde_pkg::CFG_DATA_W-1:0] chars_q;

  // Conversion state
  logic [VW-1:0] quot_q;
  logic [DW-1:0] rem_q;
  logic [SW-1:0] step_q;
  logic [CW-1:0] n_q;
  logic [AW-1:0] rd_idx_q;
  logic [DW-1:0] rd_data_q;

  // Output register
  logic                       m_valid_q;
  logic [rde_pkg::CHAR_W-1:0] m_char_q;
  logic [DW-1:0]              m_val_q;
  logic                       m_last_q;

  logic [DW-1:0] dig_mem [rde_pkg::MAX_DIGITS];

  logic [RW-1:0] eff_radix;
  logic [VW-1:0] q_next;
  logic [DW-1:0] r_next;
  logic          step_last;
  logic          out_free;
  logic [rde_pkg::CHAR_W-1:0] rd_char;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q    <= rde_pkg::RADIX_RESET;
      chars_q[0] <= rde_pkg::CHARS0_RESET;
      chars_q[1] <= rde_pkg::CHARS1_RESET;
      chars_q[2] <= rde_pkg::CHARS2_RESET;
      chars_q[3] <= rde_pkg::CHARS3_RESET;
    end else if (cfg_we_i) begin
      unique case (rde_pkg::cfg_reg_e'(cfg_idx_i))
        rde_pkg::REG_RADIX:   radix_q    <= cfg_wdata_i[RW-1:0];
        rde_pkg::REG_CHARS_0: chars_q[0] <= cfg_wdata_i;
        rde_pkg::REG_CHARS_1: chars_q[1] <= cfg_wdata_i;
        rde_pkg::REG_CHARS_2: chars_q[2] <= cfg_wdata_i;
        rde_pkg::REG_CHARS_3: chars_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp the radix into the supported range
  always_comb begin
    if (radix_q < rde_pkg::RADIX_MIN) begin
      eff_radix = rde_pkg::RADIX_MIN;
    end else if (radix_q > rde_pkg::RADIX_MAX) begin
      eff_radix = rde_pkg::RADIX_MAX;
    end else begin
      eff_radix = radix_q;
    end
  end

  // Restoring division: retire BITS_PER_CYC quotient bits per clock
  always_comb begin
    logic [DW-1:0] r_v;
    logic [RW-1:0] t_v;
    logic [VW-1:0] q_v;
    r_v = rem_q;
    q_v = quot_q;
    for (int i = 0; i < rde_pkg::BITS_PER_CYC; i++) begin
      t_v = {r_v, q_v[VW-1]};
      q_v = {q_v[VW-2:0], 1'b0};
      if (t_v >= eff_radix) begin
        t_v    = t_v - eff_radix;
        q_v[0] = 1'b1;
      end
      r_v = t_v[DW-1:0];
    end
    q_next = q_v;
    r_next = r_v;
  end

  assign step_last = (step_q == SW'(rde_pkg::DIV_CYCLES - 1));

  // Hold the dividend, remainder, step and digit count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_q   <= '0;
      rem_q    <= '0;
      step_q   <= '0;
      n_q      <= '0;
      rd_idx_q <= '0;
    end else if (cmd_i.load) begin
      quot_q <= s_axis_tdata;
      rem_q  <= '0;
      step_q <= '0;
      n_q    <= '0;
    end else if (cmd_i.div_step) begin
      quot_q <= q_next;
      if (step_last) begin
        rem_q    <= '0;
        step_q   <= '0;
        n_q      <= n_q + CW'(1);
        rd_idx_q <= n_q[AW-1:0];
      end else begin
        rem_q  <= r_next;
        step_q <= step_q + SW'(1);
      end
    end else if (cmd_i.out_load) begin
      rd_idx_q <= rd_idx_q - AW'(1);
    end
  end

  // Store each finished digit
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_step && step_last) begin
      dig_mem[n_q[AW-1:0]] <= r_next;
    end
  end

  // Read digits back, most significant first
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      rd_data_q <= dig_mem[rd_idx_q];
    end
  end

  // Map the digit to its table character
  always_comb begin
    logic [rde_pkg::CHAR_WORDS*rde_pkg::CFG_DATA_W-1:0] tbl;
    tbl = chars_q;
    if ({1'b0, rd_data_q} >= (DW + 1)'(rde_pkg::TABLE_ENTRIES)) begin
      rd_char = '0;
    end else begin
      rd_char = tbl[{rd_data_q, 3'b000} +: rde_pkg::CHAR_W];
    end
  end

  assign out_free = !m_valid_q || m_axis_tready;

  // Output register: load a digit, drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      m_char_q <= rd_char;
      m_val_q  <= rd_data_q;
      m_last_q <= (rd_idx_q == '0);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(rde_pkg::OUT_TDATA_W - rde_pkg::CHAR_W - DW)'(0), m_val_q, m_char_q};
  assign m_axis_tlast  = m_last_q;

  // Status to the controller
  assign status_o.step_last = step_last;
  assign status_o.conv_done = (q_next == '0) || (n_q == CW'(rde_pkg::MAX_DIGITS - 1));
  assign status_o.out_free  = out_free;
  assign status_o.rd_last   = (rd_idx_q == '0);

  // Digit count never passes the buffer depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CW'(rde_pkg::MAX_DIGITS))
    else $error("digit count exceeds buffer depth");

  // Partial remainder stays below the radix
  a_rem_below_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, rem_q} < eff_radix)
    else $error("partial remainder not below radix");

  // Output register is never overwritten while a digit waits
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!m_valid_q || m_axis_tready))
    else $error("output digit overwritten");

  // Read pointer tracks the most recently written digit
  a_rd_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_step && step_last) |=> (CW'(rd_idx_q) + CW'(1) == n_q))
    else $error("read pointer lost the top digit");

endmodule

[hdl/radix_digit_emitter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_emitter_unit: unsigned value to digit stream in base 2..32
// Converts each 64-bit value into its digits, most significant first, one
// output transaction per digit with its table character and a final flag.
// ----------------------------------------------------------------------------
//  Channel   Dir  Fields (low bit up)                      Marker
//  s_axis    in   tdata: value[63:0]                       -
//  m_axis    out  tdata: digit_char[7:0], digit_value[12:8] tlast = last_digit
//  cfg       in   idx 0 radix, 1..4 digit_chars words      write on cfg_we_i
//
//  Flow: accept the value, then divide out each digit at 8 quotient bits per
//  clock, then read each digit back from the buffer into the output register.
//  Reset: asynchronous, active low; no buffer clearing pass is needed.
//  Stalls: m_axis_tready low holds the readback; the next value is taken once
//  the last digit sits in the output register, before it is consumed.
// ----------------------------------------------------------------------------
module radix_digit_emitter_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [rde_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [rde_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [63:0] value
  input  logic [rde_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [7:0] digit_char, [12:8] digit_value, [15:13] zero
  output logic [rde_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                 m_axis_tlast
);

  rde_pkg::rde_cmd_t    cmd;
  rde_pkg::rde_status_t status;

  // Sequencer
  rde_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // Divider, digit buffer and output register
  rde_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for radix_digit_emitter_unit
// Streams 64-bit values through the unit under a series of radix and digit
// table settings and checks every digit transaction against a local model.
// The model runs the conversion by repeated division and keeps the digits in
// a queue. The sender works in bursts and the receiver stalls on its own
// schedule.
// ----------------------------------------------------------------------------
module tb;
  import rde_pkg::*;

  localparam int unsigned    CLK_HALF         = 2;
  localparam int unsigned    RESET_CYCLES     = 5;
  localparam int unsigned    RANDOM_PHASES    = 8;
  localparam int unsigned    VALUES_PER_PHASE = 31;
  localparam int unsigned    MAX_LOW_RUN      = 3;
  localparam int unsigned    SETTLE_CYCLES    = 700;
  localparam longint unsigned CYCLE_LIMIT     = 1_000_000;
  localparam logic [VALUE_W-1:0] ALL_ONES     = '1;
  localparam logic [VALUE_W-1:0] TOP_BIT      = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic [DIGIT_W-1:0] val;
    logic               last;
  } digit_t;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_PERIODIC
  } sink_mode_e;

  // Digit model: mirrors the register file and holds the digits still owed
  class digit_scoreboard;
    logic [RADIX_W-1:0]    radix;
    logic [CFG_DATA_W-1:0] chars [CHAR_WORDS];
    digit_t                pending [$];
    int unsigned           errors;
    int unsigned           values_seen;
    int unsigned           digits_seen;

    function new();
      radix       = RADIX_RESET;
      chars[0]    = CHARS0_RESET;
      chars[1]    = CHARS1_RESET;
      chars[2]    = CHARS2_RESET;
      chars[3]    = CHARS3_RESET;
      errors      = 0;
      values_seen = 0;
      digits_seen = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_RADIX:   radix    = data[RADIX_W-1:0];
        REG_CHARS_0: chars[0] = data;
        REG_CHARS_1: chars[1] = data;
        REG_CHARS_2: chars[2] = data;
        REG_CHARS_3: chars[3] = data;
        default: ;
      endcase
    endfunction

    // Divide down to digits, then queue them most significant first
    function void note_value(logic [VALUE_W-1:0] value);
      logic [VALUE_W-1:0] quot;
      logic [VALUE_W-1:0] base;
      logic [DIGIT_W-1:0] lsd_first [MAX_DIGITS];
      int unsigned        n;
      digit_t             d;
      base = VALUE_W'((radix < RADIX_MIN) ? RADIX_MIN :
                      ((radix > RADIX_MAX) ? RADIX_MAX : radix));
      quot = value;
      n    = 0;
      do begin
        lsd_first[n] = DIGIT_W'(quot % base);
        quot         = quot / base;
        n++;
      end while (quot != 0 && n < MAX_DIGITS);
      // a 5-bit digit always falls inside the 32-entry table
      for (int k = int'(n); k > 0; k--) begin
        d.val  = lsd_first[k-1];
        d.ch   = chars[d.val[4:3]][{d.val[2:0], 3'b000} +: CHAR_W];
        d.last = (k == 1);
        pending.push_back(d);
      end
      values_seen++;
    endfunction

    function void mismatch(string field, logic [15:0] want, logic [15:0] got);
      errors++;
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, field, want, got);
    endfunction

    function void check_digit(logic [OUT_TDATA_W-1:0] tdata, logic tlast);
      digit_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t ns: digit with none expected, expected none actual tdata %h tlast %b",
                 $time, tdata, tlast);
        return;
      end
      want = pending.pop_front();
      digits_seen++;
      if (tdata[CHAR_W-1:0] !== want.ch)
        mismatch("digit_char", 16'(want.ch), 16'(tdata[CHAR_W-1:0]));
      if (tdata[CHAR_W +: DIGIT_W] !== want.val)
        mismatch("digit_value", 16'(want.val), 16'(tdata[CHAR_W +: DIGIT_W]));
      if (tdata[OUT_TDATA_W-1:CHAR_W+DIGIT_W] !== '0)
        mismatch("tdata pad", 16'h0, 16'(tdata[OUT_TDATA_W-1:CHAR_W+DIGIT_W]));
      if (tlast !== want.last)
        mismatch("last_digit", 16'(want.last), 16'(tlast));
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [63:0] value
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [7:0] digit_char, [12:8] digit_value, [15:13] zero
  logic                   m_axis_tlast;   // last_digit

  digit_scoreboard sb;
  int unsigned     burst_left;
  int unsigned     phases_run;
  sink_mode_e      sink_mode;
  int unsigned     sink_window;
  int unsigned     low_run;
  int unsigned     sink_tick;
  longint unsigned cycles;

  radix_digit_emitter_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock
  initial clk_i = 1'b0;
  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Run guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t ns: run stopped at the cycle limit", $time);
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: check each digit transaction, then pick the next ready level
  always @(posedge clk_i) begin
    logic ready_next;
    if (rst_ni) begin
      if (m_axis_tvalid === 1'b1 && m_axis_tready)
        sb.check_digit(m_axis_tdata, m_axis_tlast);
      if (sink_window == 0) begin
        sink_mode   = sink_mode_e'($urandom_range(0, 2));
        sink_window = $urandom_range(20, 80);
      end else begin
        sink_window--;
      end
      sink_tick++;
      case (sink_mode)
        SINK_RANDOM:   ready_next = 1'($urandom_range(0, 1));
        SINK_PERIODIC: ready_next = (sink_tick % 3) != 0;
        default:       ready_next = 1'b1;
      endcase
      if (ready_next) begin
        low_run = 0;
      end else if (low_run >= MAX_LOW_RUN) begin
        ready_next = 1'b1;
        low_run    = 0;
      end else begin
        low_run++;
      end
      m_axis_tready <= ready_next;
    end
  end

  // Pick a value: edges, single bits, short and full-width numbers
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return VALUE_W'($urandom_range(0, 40));
      3:       return VALUE_W'(1) << $urandom_range(0, 63);
      4, 5:    return v;
      default: return v >> $urandom_range(0, 63);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_chars();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Radix word with random upper bits; low bits often at or past the clamps
  function automatic logic [CFG_DATA_W-1:0] pick_radix();
    logic [CFG_DATA_W-1:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       w[RADIX_W-1:0] = '0;
      1:       w[RADIX_W-1:0] = RADIX_W'(1);
      2:       w[RADIX_W-1:0] = RADIX_MIN;
      3:       w[RADIX_W-1:0] = RADIX_MAX;
      4:       w[RADIX_W-1:0] = RADIX_W'($urandom_range(33, 63));
      default: w[RADIX_W-1:0] = RADIX_W'($urandom_range(2, 32));
    endcase
    return w;
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic set_config(logic [CFG_DATA_W-1:0] radix_word, logic [CFG_DATA_W-1:0] c0,
                            logic [CFG_DATA_W-1:0] c1, logic [CFG_DATA_W-1:0] c2,
                            logic [CFG_DATA_W-1:0] c3);
    write_reg(REG_RADIX, radix_word);
    write_reg(REG_CHARS_0, c0);
    write_reg(REG_CHARS_1, c1);
    write_reg(REG_CHARS_2, c2);
    write_reg(REG_CHARS_3, c3);
    cfg_we_i <= 1'b0;
    phases_run++;
  endtask

  // Offer one value; hold valid through the burst, drop it for the gap after
  task automatic push_value(logic [VALUE_W-1:0] value);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_value(value);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
    end
  endtask

  // Stop sending and wait until every owed digit has come back
  task automatic drain();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    sb            = new();
    cycles        = 0;
    burst_left    = 1;
    phases_run    = 0;
    sink_mode     = SINK_OPEN;
    sink_window   = 0;
    low_run       = 0;
    sink_tick     = 0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_RADIX;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: decimal with the default table
    push_value('0);
    push_value(64'd1);
    push_value(64'd9);
    push_value(64'd10);
    push_value(ALL_ONES);
    push_value(TOP_BIT);
    drain();

    // Radix below two clamps to binary; full width gives 64 digits
    set_config('0, '1, '0, '1, '0);
    push_value(ALL_ONES);
    push_value('0);
    push_value(64'd1);
    push_value(64'h5555_5555_5555_5555);
    drain();

    // Largest radix, upper bits of the write word set
    set_config({{(CFG_DATA_W-RADIX_W){1'b1}}, RADIX_MAX}, pick_chars(), pick_chars(),
               {$urandom, $urandom}, {$urandom, $urandom});
    push_value(ALL_ONES);
    push_value(64'd31);
    push_value(64'd32);
    push_value(64'd1024);
    drain();

    // Radix above 32 clamps down
    set_config(CFG_DATA_W'(63), '1, '1, '1, '1);
    push_value(ALL_ONES);
    push_value('0);
    drain();

    // Radix one clamps up
    set_config(CFG_DATA_W'(1), CHARS0_RESET, CHARS1_RESET, '0, '0);
    push_value(64'd5);
    push_value(TOP_BIT);
    drain();

    // Hex and base three
    set_config(CFG_DATA_W'(16), CHARS0_RESET, CHARS1_RESET, {$urandom, $urandom},
               {$urandom, $urandom});
    push_value(64'hDEAD_BEEF_0123_4567);
    push_value(64'd255);
    drain();
    set_config(CFG_DATA_W'(3), {$urandom, $urandom}, {$urandom, $urandom}, '0, '0);
    push_value(ALL_ONES);
    push_value(64'd2);
    drain();

    // Random settings, each followed by a batch of random values
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_config(pick_radix(), pick_chars(), pick_chars(), pick_chars(), pick_chars());
      for (int i = 0; i < VALUES_PER_PHASE; i++) push_value(pick_value());
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.pending.size() != 0) begin
      sb.errors++;
      $display("%0t ns: %0d digits never arrived, expected 0 actual %0d",
               $time, sb.pending.size(), sb.pending.size());
    end
    $display("tb: %0d values converted into %0d checked digits", sb.values_seen,
             sb.digits_seen);
    $display("tb: %0d register settings, radix clamps and table extremes included", phases_run);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
